// ===== hw/rtl/ehs_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder homing sequencer package
// Shared types, codes and drive levels for the encoder homing sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ehs_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned LEVEL_W     = 10;
  localparam int unsigned WHEEL_W     = 16;
  localparam int unsigned ZONE_W      = 15;
  localparam int unsigned LIMIT_W     = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_OFF    = 10'h000;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 10'h0ff;
  localparam logic [LEVEL_W-1:0] LEVEL_SLOW   = 10'h1ff;
  localparam logic [LEVEL_W-1:0] LEVEL_CRUISE = 10'h2ff;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 10'h3ff;

  localparam logic [ZONE_W-1:0]  ZONE_RESET   = 15'd3000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd7500;
  localparam logic [LIMIT_W-1:0] MARGIN_RESET = 16'd500;

  typedef enum logic [1:0] {
    MODE_EDGE_A = 2'd0,
    MODE_EDGE_B = 2'd1,
    MODE_TICK   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DIR_STOP  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    PH_SEEK_LEFT  = 3'd0,
    PH_SEEK_RIGHT = 3'd1,
    PH_APPROACH   = 3'd2,
    PH_RETURN     = 3'd3,
    PH_DONE       = 3'd4
  } phase_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEFT_SEEK_SLOW_ZONE   = 2'd0,
    CFG_RIGHT_SEEK_FAST_LIMIT = 2'd1,
    CFG_CENTER_MARGIN         = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ZONE_W-1:0]  left_seek_slow_zone;
    logic [LIMIT_W-1:0] right_seek_fast_limit;
    logic [LIMIT_W-1:0] center_margin;
  } ehs_cfg_t;

  typedef struct packed {
    dir_e               drive_direction;
    logic [LEVEL_W-1:0] drive_level;
    logic [WHEEL_W-1:0] wheel_position;
    logic               calibrated;
  } ehs_result_t;

endpackage

// ===== hw/rtl/ehs_core.sv =====
// ----------------------------------------------------------------------------
// Encoder homing sequencer core
// Position counter and homing state machine; steps once per event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ehs_core #(
  parameter int unsigned POSITION_BITS = ehs_pkg::POSITION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [1:0]           mode_i,
  input  logic                 pin_a_i,
  input  logic                 pin_b_i,
  input  ehs_pkg::ehs_cfg_t    cfg_i,
  output ehs_pkg::ehs_result_t result_o
);
  import ehs_pkg::*;

  localparam int unsigned PosW = POSITION_BITS;
  localparam int unsigned CmpW = ((PosW > WHEEL_W) ? PosW : WHEEL_W) + 1;

  localparam logic [PosW-1:0] HalfMax = {1'b0, {(PosW-1){1'b1}}};

  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    last_q, last_d;
  logic [PosW-1:0]    center_q, center_d;
  phase_e             phase_q, phase_d;
  dir_e               dir_q, dir_d;
  logic [LEVEL_W-1:0] level_q, level_d;

  logic               same;
  logic [CmpW-1:0]    pos_ext;
  logic [CmpW-1:0]    left_sum;
  logic [PosW-1:0]    appr_center;
  logic [CmpW-1:0]    appr_sum;
  logic [LEVEL_W-1:0] left_level;
  logic [LEVEL_W-1:0] right_level;
  logic [LEVEL_W-1:0] appr_level;
  logic [CmpW-1:0]    wheel_ext;

  assign same     = (pin_a_i == pin_b_i);
  assign pos_ext  = CmpW'(pos_q);
  assign left_sum = pos_ext + CmpW'(cfg_i.left_seek_slow_zone);

  assign left_level  = (left_sum < CmpW'(HalfMax)) ? LEVEL_SLOW : LEVEL_CRUISE;
  assign right_level = (pos_ext < CmpW'(cfg_i.right_seek_fast_limit)) ? LEVEL_FULL : LEVEL_SLOW;

  assign appr_center = (phase_q == PH_SEEK_RIGHT) ? (pos_q >> 1) : center_q;
  assign appr_sum    = CmpW'(appr_center) + CmpW'(cfg_i.center_margin);
  assign appr_level  = (pos_ext > appr_sum) ? LEVEL_FULL : LEVEL_LOW;

  always_comb begin
    pos_d    = pos_q;
    last_d   = last_q;
    center_d = center_q;
    phase_d  = phase_q;
    dir_d    = dir_q;
    level_d  = level_q;
    case (mode_e'(mode_i))
      MODE_EDGE_A: begin
        pos_d = same ? (pos_q - PosW'(1)) : (pos_q + PosW'(1));
      end
      MODE_EDGE_B: begin
        pos_d = same ? (pos_q + PosW'(1)) : (pos_q - PosW'(1));
      end
      MODE_TICK: begin
        case (phase_q)
          PH_SEEK_LEFT: begin
            if (pos_q == last_q) begin
              pos_d   = '0;
              last_d  = '0;
              phase_d = PH_SEEK_RIGHT;
              dir_d   = DIR_RIGHT;
              level_d = (cfg_i.right_seek_fast_limit != '0) ? LEVEL_FULL : LEVEL_SLOW;
            end else begin
              last_d  = pos_q;
              dir_d   = DIR_LEFT;
              level_d = left_level;
            end
          end
          PH_SEEK_RIGHT: begin
            if (pos_q == last_q) begin
              center_d = appr_center;
              phase_d  = PH_APPROACH;
              dir_d    = DIR_LEFT;
              level_d  = appr_level;
            end else begin
              last_d  = pos_q;
              dir_d   = DIR_RIGHT;
              level_d = right_level;
            end
          end
          PH_APPROACH: begin
            if (pos_q > center_q) begin
              dir_d   = DIR_LEFT;
              level_d = appr_level;
            end else begin
              phase_d = PH_RETURN;
              dir_d   = DIR_RIGHT;
              level_d = LEVEL_LOW;
            end
          end
          PH_RETURN: begin
            if (pos_q >= center_q) begin
              phase_d = PH_DONE;
              dir_d   = DIR_STOP;
              level_d = LEVEL_OFF;
            end
          end
          default: begin
            phase_d = PH_DONE;
            dir_d   = DIR_STOP;
            level_d = LEVEL_OFF;
          end
        endcase
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= HalfMax;
      last_q   <= HalfMax;
      center_q <= '0;
      phase_q  <= PH_SEEK_LEFT;
      dir_q    <= DIR_LEFT;
      level_q  <= LEVEL_CRUISE;
    end else if (step_i) begin
      pos_q    <= pos_d;
      last_q   <= last_d;
      center_q <= center_d;
      phase_q  <= phase_d;
      dir_q    <= dir_d;
      level_q  <= level_d;
    end
  end

  assign wheel_ext = CmpW'(pos_d);

  assign result_o.drive_direction = dir_d;
  assign result_o.drive_level     = level_d;
  assign result_o.wheel_position  = wheel_ext[WHEEL_W-1:0];
  assign result_o.calibrated      = (phase_d == PH_DONE);

endmodule

// ===== hw/rtl/encoder_homing_sequencer.sv =====
// ----------------------------------------------------------------------------
// Encoder homing sequencer
// An event is held in the input register, and its result in the output register.
// Throughput: one event per cycle while the result stream is not stalled.
// The input register is refilled in the cycle that the output register loads.
// Reset: position 2^(POSITION_BITS-1)-1, seek left at level 0x2ff, registers
// at their defaults, both stream sides empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_homing_sequencer #(
  parameter int unsigned POSITION_BITS = ehs_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ehs_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [ehs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // Fields from bit 0: pin_a, pin_b, zero fill.
  input  logic [ehs_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // Fields from bit 0: mode.
  input  logic [ehs_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // Fields from bit 0: drive_direction, drive_level, wheel_position,
  // calibrated, zero fill.
  output logic [ehs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import ehs_pkg::*;

  ehs_cfg_t    cfg_q;
  logic        in_valid_q;
  logic [1:0]  mode_q;
  logic        pin_a_q;
  logic        pin_b_q;
  logic        out_valid_q;
  ehs_result_t out_q;
  ehs_result_t result;
  logic        advance;
  logic        in_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_seek_slow_zone   <= ZONE_RESET;
      cfg_q.right_seek_fast_limit <= LIMIT_RESET;
      cfg_q.center_margin         <= MARGIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT_SEEK_SLOW_ZONE:   cfg_q.left_seek_slow_zone   <= cfg_data_i[ZONE_W-1:0];
        CFG_RIGHT_SEEK_FAST_LIMIT: cfg_q.right_seek_fast_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_CENTER_MARGIN:         cfg_q.center_margin         <= cfg_data_i[LIMIT_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      mode_q  <= s_axis_tuser_i;
      pin_a_q <= s_axis_tdata_i[0];
      pin_b_q <= s_axis_tdata_i[1];
    end
  end

  ehs_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .mode_i   (mode_q),
    .pin_a_i  (pin_a_q),
    .pin_b_i  (pin_b_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.calibrated, out_q.wheel_position,
                            out_q.drive_level, out_q.drive_direction};

endmodule

// ===== hw/rtl/ehs_checker.sv =====
// ----------------------------------------------------------------------------
// Encoder homing sequencer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ehs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [ehs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import ehs_pkg::*;

  logic [1:0]         dir;
  logic [LEVEL_W-1:0] level;
  logic               cal;
  logic               cal_seen_q;

  assign dir   = m_axis_tdata_o[1:0];
  assign level = m_axis_tdata_o[11:2];
  assign cal   = m_axis_tdata_o[28];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_seen_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i && cal) begin
      cal_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Result changed while stalled.");

  a_stop_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((dir == DIR_STOP) == cal) && ((level == LEVEL_OFF) == cal))
    else $error("Stop and zero drive must coincide with calibration.");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (dir == DIR_STOP || dir == DIR_LEFT || dir == DIR_RIGHT))
    else $error("Unused drive direction code on output.");

  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && cal_seen_q |-> cal)
    else $error("Calibrated flag dropped after homing finished.");

endmodule

bind encoder_homing_sequencer ehs_checker u_ehs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
